@@ hw/rtl/dewp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dewp_pkg
// Shared types, codes and constants of the detector event word parser.
// ----------------------------------------------------------------------------
package dewp_pkg;

    localparam int ADDRESS_BITS = 16;
    localparam int BOARD_SLOTS  = 16;
    localparam int BOARD_BITS   = $clog2(BOARD_SLOTS);

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_CHAN  = 2'd1,
        OP_BOARD = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SCALAR = 2'd1,
        ST_ADDR   = 2'd2,
        ST_BADTYP = 2'd3
    } status_t;

    localparam logic [3:0] WT_HEADER  = 4'h8;
    localparam logic [3:0] WT_TRIGREQ = 4'h9;
    localparam logic [3:0] WT_TSLOW   = 4'hA;
    localparam logic [3:0] WT_TSHIGH  = 4'hB;
    localparam logic [3:0] WT_AUX0    = 4'hC;
    localparam logic [3:0] WT_AUX1    = 4'hD;
    localparam logic [3:0] WT_TRAILER = 4'hE;
    localparam logic [3:0] WT_BAD     = 4'hF;

    localparam logic [3:0]  DT_SCALAR    = 4'hF;
    localparam logic [3:0]  DT_SIGNED    = 4'd6;
    localparam logic [3:0]  DT_TRIG_LIM  = 4'd12;
    localparam logic [15:0] ADDR_NONE    = 16'hFFFF;
    localparam logic [31:0] TRAILER_ANY  = 32'hEFFFFFFF;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        word;
        logic [15:0]        table_index;
        logic signed [15:0] table_value;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        address;
        logic signed [15:0] channel;
        logic [3:0]         data_type;
        logic [41:0]        timestamp;
        logic [13:0]        deadtime;
        logic [4:0]         pileup;
        logic signed [31:0] energy;
        logic [21:0]        cfd_time;
        logic [13:0]        trigger_accepted;
        logic signed [31:0] source_id;
        logic [3:0]         error_flags;
    } out_t;

    // data word on its way from the front end to the event stage
    typedef struct packed {
        logic        valid;
        logic [31:0] word;
        logic [15:0] address;
    } pipe_t;

    function automatic out_t rec_clear();
        out_t r;
        r           = '0;
        r.source_id = -32'sd1;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dewp_chan_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dewp_chan_ram
// Address-to-channel table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dewp_chan_ram (
    input  wire                                aclk,
    input  wire                                wr_en,
    input  wire [dewp_pkg::ADDRESS_BITS-1:0]   wr_addr,
    input  wire [15:0]                         wr_data,
    input  wire                                rd_en,
    input  wire [dewp_pkg::ADDRESS_BITS-1:0]   rd_addr,
    output logic [15:0]                        rd_data
);

    logic [15:0] mem [0:(1 << dewp_pkg::ADDRESS_BITS)-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/dewp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dewp_front
// Board table, header address remap and channel table access.
// ----------------------------------------------------------------------------
module dewp_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   accept,
    input  wire                   advance,
    input  dewp_pkg::in_t         in_data,
    output dewp_pkg::pipe_t       pipe,
    output logic [15:0]           chan_data
);

    logic [7:0]  board_reg [0:dewp_pkg::BOARD_SLOTS-1];
    logic [15:0] raw_addr;
    logic [7:0]  slot_id;
    logic [15:0] map_addr;
    logic        is_data;
    logic        pipe_valid_reg;
    logic [31:0] pipe_word_reg;
    logic [15:0] pipe_addr_reg;

    assign is_data  = (in_data.opcode == dewp_pkg::OP_DATA);
    assign raw_addr = in_data.word[19:4];
    assign slot_id  = board_reg[raw_addr[15:16-dewp_pkg::BOARD_BITS]];

    always_comb begin
        map_addr = raw_addr;
        if (raw_addr[15] && !slot_id[7]) begin
            map_addr = {1'b1, slot_id[6:0], raw_addr[7:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dewp_pkg::BOARD_SLOTS; i++) begin
                board_reg[i] <= 8'hFF;
            end
        end else if (accept && in_data.opcode == dewp_pkg::OP_BOARD) begin
            board_reg[in_data.table_index[dewp_pkg::BOARD_BITS-1:0]] <=
                in_data.table_value[7:0];
        end
    end

    // drop the stage when it moves on without a new data beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
        end else if (advance) begin
            pipe_valid_reg <= accept && is_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pipe_word_reg <= in_data.word;
            pipe_addr_reg <= map_addr;
        end
    end

    assign pipe = '{valid: pipe_valid_reg, word: pipe_word_reg, address: pipe_addr_reg};

    dewp_chan_ram u_chan_ram (
        .aclk    (aclk),
        .wr_en   (accept && in_data.opcode == dewp_pkg::OP_CHAN),
        .wr_addr (in_data.table_index[dewp_pkg::ADDRESS_BITS-1:0]),
        .wr_data (in_data.table_value),
        .rd_en   (accept && is_data),
        .rd_addr (map_addr[dewp_pkg::ADDRESS_BITS-1:0]),
        .rd_data (chan_data)
    );

endmodule
`default_nettype wire

@@ hw/rtl/dewp_event.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dewp_event
// Per-event state, word decode and the result register.
// ----------------------------------------------------------------------------
module dewp_event (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  dewp_pkg::pipe_t       pipe,
    input  wire [15:0]            chan_data,
    input  wire                   m_ready,
    output logic                  advance,
    output logic                  m_valid,
    output dewp_pkg::out_t        m_data
);

    dewp_pkg::out_t rec_reg, rec_next, emit_rec;
    logic [1:0]  wpos_reg, wpos_next;
    logic [3:0]  pcnt_reg, pcnt_next;
    logic        expm_reg, expm_next;
    logic [1:0]  drop_reg, drop_next;
    logic        scal_reg, scal_next;
    logic [27:0] treq_reg, treq_next;
    logic        emit_raw;
    logic        emit;
    logic        m_valid_reg;
    dewp_pkg::out_t m_data_reg;

    always_comb begin
        logic [31:0] w;
        logic [31:0] wm;
        logic [3:0]  wt;
        logic        done;
        logic [3:0]  pc;
        logic signed [15:0] ch;
        w         = pipe.word;
        wt        = w[31:28];
        wm        = w;
        done      = 1'b0;
        pc        = pcnt_reg;
        ch        = chan_data;
        rec_next  = rec_reg;
        wpos_next = wpos_reg;
        pcnt_next = pcnt_reg;
        expm_next = expm_reg;
        drop_next = drop_reg;
        scal_next = scal_reg;
        treq_next = treq_reg;
        emit_raw  = 1'b0;
        if (pipe.valid) begin
            if (drop_reg != dewp_pkg::ST_OK) begin
                emit_raw = (wt == dewp_pkg::WT_TRAILER);
            end else begin
                if (expm_reg) begin
                    expm_next = 1'b0;
                    if (!w[31]) begin
                        rec_next.source_id = w;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    if (wpos_reg == 2'd0 && !w[31]) begin
                        rec_next.error_flags[0] = 1'b1;
                    end
                    case (wt)
                        dewp_pkg::WT_HEADER: begin
                            if (wpos_reg != 2'd0) begin
                                rec_next.error_flags[0] = 1'b1;
                            end
                            pcnt_next          = '0;
                            rec_next.data_type = w[3:0];
                            rec_next.address   = pipe.address;
                            rec_next.channel   = ch;
                            if (w[3:0] != dewp_pkg::DT_SCALAR && ch[15] &&
                                pipe.address != dewp_pkg::ADDR_NONE) begin
                                rec_next.error_flags[1] = 1'b1;
                                drop_next = dewp_pkg::ST_ADDR;
                            end
                        end
                        dewp_pkg::WT_TRIGREQ: treq_next = w[27:0];
                        dewp_pkg::WT_TSLOW:   rec_next.timestamp = {14'd0, w[27:0]};
                        dewp_pkg::WT_TSHIGH: begin
                            rec_next.timestamp[41:28] = rec_reg.timestamp[41:28] | w[13:0];
                            rec_next.deadtime         = w[27:14];
                        end
                        dewp_pkg::WT_TRAILER: begin
                            rec_next.trigger_accepted = w[27:14];
                            if (rec_reg.data_type < dewp_pkg::DT_TRIG_LIM &&
                                w[13:0] != treq_reg[13:0] && w != dewp_pkg::TRAILER_ANY) begin
                                rec_next.error_flags[3] = 1'b1;
                            end
                            emit_raw = 1'b1;
                        end
                        dewp_pkg::WT_BAD: drop_next = dewp_pkg::ST_BADTYP;
                        dewp_pkg::WT_AUX0, dewp_pkg::WT_AUX1: ;
                        default: begin
                            if (rec_reg.data_type == dewp_pkg::DT_SCALAR) begin
                                if (rec_reg.address != dewp_pkg::ADDR_NONE) begin
                                    scal_next = 1'b1;
                                end
                            end else if (wpos_reg != 2'd3) begin
                                if (rec_reg.address != dewp_pkg::ADDR_NONE) begin
                                    rec_next.pileup = w[4:0];
                                    expm_next       = 1'b1;
                                end
                            end else begin
                                if (rec_reg.data_type == dewp_pkg::DT_SIGNED && w[29]) begin
                                    wm[31:30] = 2'b11;
                                end
                                if (pc < 4'd8) begin
                                    pc = pc + 4'd1;
                                end
                                pcnt_next = pc;
                                if (pc == 4'd1) begin
                                    rec_next.energy =
                                        (rec_reg.data_type == dewp_pkg::DT_SIGNED) ?
                                        wm : {7'd0, wm[24:0]};
                                end else if (pc == 4'd2) begin
                                    rec_next.cfd_time =
                                        (rec_reg.data_type == dewp_pkg::DT_SIGNED) ?
                                        {12'd0, wm[9:0]} : wm[21:0];
                                end else if (pc == 4'd8) begin
                                    rec_next.error_flags[2] = 1'b1;
                                end
                            end
                        end
                    endcase
                end
                if (wt != dewp_pkg::WT_TRAILER && wpos_reg != 2'd3) begin
                    wpos_next = wpos_reg + 2'd1;
                end
            end
        end
    end

    // hold only a closing beat that finds the result register still occupied
    assign advance = !(emit_raw && m_valid_reg && !m_ready);
    assign emit    = emit_raw && advance;

    always_comb begin
        emit_rec = rec_next;
        if (drop_next != dewp_pkg::ST_OK) begin
            emit_rec.status = drop_next;
        end else if (scal_next) begin
            emit_rec.status = dewp_pkg::ST_SCALAR;
        end else begin
            emit_rec.status = dewp_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg  <= dewp_pkg::rec_clear();
            wpos_reg <= '0;
            pcnt_reg <= '0;
            expm_reg <= 1'b0;
            drop_reg <= dewp_pkg::ST_OK;
            scal_reg <= 1'b0;
            treq_reg <= '0;
        end else if (emit) begin
            // trailer closes the event: return to the clean record
            rec_reg  <= dewp_pkg::rec_clear();
            wpos_reg <= '0;
            pcnt_reg <= '0;
            expm_reg <= 1'b0;
            drop_reg <= dewp_pkg::ST_OK;
            scal_reg <= 1'b0;
            treq_reg <= '0;
        end else if (advance) begin
            rec_reg  <= rec_next;
            wpos_reg <= wpos_next;
            pcnt_reg <= pcnt_next;
            expm_reg <= expm_next;
            drop_reg <= drop_next;
            scal_reg <= scal_next;
            treq_reg <= treq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= emit_rec;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

@@ hw/rtl/detector_event_word_parser_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detector_event_word_parser_top
// Parses detector stream words into one event record per trailer word.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry input beats: data words (opcode 0) and
//   writes of the channel table (opcode 1) and board table (opcode 2).
//   m_valid/m_ready/m_data carry one event record per trailer word.
//   Throughput: one beat per cycle while s_ready is high.
//   A trailer beat is registered in the front stage at accept, while the channel
//   table is read; its record is then decoded into the register behind m_valid.
//   The channel table is a 2**ADDRESS_BITS entry synchronous RAM read at
//   accept time; the board table sits in flops.
//   Reset clears all event state and sets every board entry to none; the
//   channel table holds no defined contents until written.
//   While a record waits on a stalled m_ready, beats keep flowing; only a
//   trailer reaching decode holds s_ready low until the record is taken.
// ----------------------------------------------------------------------------
module detector_event_word_parser_top (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  dewp_pkg::in_t     s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output dewp_pkg::out_t    m_data
);

    dewp_pkg::pipe_t pipe;
    logic [15:0]     chan_data;
    logic            advance;

    assign s_ready = advance;

    dewp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_valid && s_ready),
        .advance   (advance),
        .in_data   (s_data),
        .pipe      (pipe),
        .chan_data (chan_data)
    );

    dewp_event u_event (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe      (pipe),
        .chan_data (chan_data),
        .m_ready   (m_ready),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input held without a stalled record");

    a_addr_drop_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == dewp_pkg::ST_ADDR) |-> m_data.error_flags[1])
        else $error("address drop without address error flag");

    a_record_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled record changed");

endmodule
`default_nettype wire
